### rtl/assert_macros.svh
// Assertion macros shared by the RTL of the command queue.
// No dependencies; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked during reset.
`define OCC_ASSERT_IMPLIES(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// Next-cycle implication, masked during reset.
`define OCC_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

### rtl/occ_pkg.sv
// Shared types and codes for the ordered command queue.
// No dependencies; used by occ_seq, occ_entry_mem and ordered_command_queue.
package occ_pkg;

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_POP    = 2'd1;
   localparam logic [1:0] OP_DELETE = 2'd2;
   localparam logic [1:0] OP_FLUSH  = 2'd3;

   localparam logic [2:0] ST_HEAD_INSERT  = 3'd0;
   localparam logic [2:0] ST_LATER_INSERT = 3'd1;
   localparam logic [2:0] ST_NEXT_PENDING = 3'd2;
   localparam logic [2:0] ST_NONE_PENDING = 3'd3;
   localparam logic [2:0] ST_DELETED      = 3'd4;
   localparam logic [2:0] ST_NOT_FOUND    = 3'd5;
   localparam logic [2:0] ST_FLUSHED      = 3'd6;
   localparam logic [2:0] ST_FULL         = 3'd7;

   localparam logic [1:0] DEST_MASTER = 2'd0;
   localparam logic [1:0] DEST_NAV    = 2'd1;
   localparam logic [1:0] DEST_CAMERA = 2'd2;

   localparam logic MSG_POSITION = 1'b0;
   localparam logic MSG_CAMERA   = 1'b1;

   typedef struct packed {
      logic [1:0]  operation;
      logic [31:0] ref_id;
      logic        command_kind;
      logic [63:0] latitude_in;
      logic [63:0] longitude_in;
   } cmd_req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic        notify;
      logic [1:0]  destination;
      logic        message_kind;
      logic [63:0] latitude_out;
      logic [63:0] longitude_out;
      logic [31:0] assigned_id;
   } cmd_rsp_type;

   // write strobes into the entry store
   typedef struct packed {
      logic data_we;
      logic link_we;
   } mem_we_type;

endpackage

### rtl/ordered_command_queue.sv
// Top level of the ordered command queue: stream ports, result register.
// Instantiates occ_seq and occ_entry_mem; uses occ_pkg.
//
//   port group | direction | payload
//   req_       | in        | tuser: operation, command_kind; tdata: ref_id, latitude, longitude
//   rsp_       | out       | tuser: status, notify, destination, message_kind;
//              |           | tdata: latitude, longitude, assigned_id
//
// One transaction at a time. Delete walks the list, one entry a cycle through the
// registered read port; insert runs a free-slot scan plus a list walk.
// Reset is synchronous; afterwards the queue is empty and ready at once.
// The result register lets the sequencer finish while a result is stalled; the
// next transaction is taken and run, but its result waits until the register frees.
module ordered_command_queue #(
   parameter int unsigned QUEUE_DEPTH = 16,
   parameter int unsigned ID_BITS     = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [159:0] req_tdata,  // ref_id[31:0], latitude_in[95:32], longitude_in[159:96]
   input  logic [2:0]   req_tuser,  // operation[1:0], command_kind[2]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [159:0] rsp_tdata,  // latitude_out[63:0], longitude_out[127:64],
                                    // assigned_id[159:128]
   output logic [6:0]   rsp_tuser   // status[2:0], notify[3], destination[5:4],
                                    // message_kind[6]
);
   import occ_pkg::*;

   localparam int unsigned SLOT_BITS = $clog2(QUEUE_DEPTH);
   localparam int unsigned LINK_BITS = $clog2(QUEUE_DEPTH + 1);

   cmd_req_type          req;
   cmd_rsp_type          res;
   logic                 res_valid;
   logic                 res_ready;
   logic                 rsp_valid_ff;
   cmd_rsp_type          rsp_data_ff;

   mem_we_type           mem_we;
   logic [SLOT_BITS-1:0] mem_waddr;
   logic [SLOT_BITS-1:0] mem_raddr;
   logic [ID_BITS-1:0]   wr_id;
   logic                 wr_kind;
   logic [63:0]          wr_lat;
   logic [63:0]          wr_lon;
   logic [LINK_BITS-1:0] wr_link;
   logic [ID_BITS-1:0]   rd_id;
   logic                 rd_kind;
   logic [63:0]          rd_lat;
   logic [63:0]          rd_lon;
   logic [LINK_BITS-1:0] rd_link;

   assign req.operation    = req_tuser[1:0];
   assign req.command_kind = req_tuser[2];
   assign req.ref_id       = req_tdata[31:0];
   assign req.latitude_in  = req_tdata[95:32];
   assign req.longitude_in = req_tdata[159:96];

   // result register frees the sequencer once its result is parked
   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_ready) begin
         rsp_valid_ff <= res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (res_ready && res_valid) begin
         rsp_data_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_data_ff.assigned_id, rsp_data_ff.longitude_out,
                        rsp_data_ff.latitude_out};
   assign rsp_tuser  = {rsp_data_ff.message_kind, rsp_data_ff.destination,
                        rsp_data_ff.notify, rsp_data_ff.status};

   occ_seq #(
      .DEPTH   (QUEUE_DEPTH),
      .ID_BITS (ID_BITS)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req       (req),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res       (res),
      .mem_we    (mem_we),
      .mem_waddr (mem_waddr),
      .wr_id     (wr_id),
      .wr_kind   (wr_kind),
      .wr_lat    (wr_lat),
      .wr_lon    (wr_lon),
      .wr_link   (wr_link),
      .mem_raddr (mem_raddr),
      .rd_id     (rd_id),
      .rd_kind   (rd_kind),
      .rd_lat    (rd_lat),
      .rd_lon    (rd_lon),
      .rd_link   (rd_link)
   );

   occ_entry_mem #(
      .DEPTH   (QUEUE_DEPTH),
      .ID_BITS (ID_BITS)
   ) u_mem (
      .clock   (clock),
      .we      (mem_we),
      .waddr   (mem_waddr),
      .wr_id   (wr_id),
      .wr_kind (wr_kind),
      .wr_lat  (wr_lat),
      .wr_lon  (wr_lon),
      .wr_link (wr_link),
      .raddr   (mem_raddr),
      .rd_id   (rd_id),
      .rd_kind (rd_kind),
      .rd_lat  (rd_lat),
      .rd_lon  (rd_lon),
      .rd_link (rd_link)
   );

endmodule

### rtl/occ_entry_mem.sv
// Entry store: id, kind, position words and link of every queue slot.
// One write port, one read port with registered data. Uses occ_pkg.
module occ_entry_mem #(
   parameter int unsigned DEPTH     = 16,
   parameter int unsigned ID_BITS   = 32,
   localparam int unsigned SLOT_BITS = $clog2(DEPTH),
   localparam int unsigned LINK_BITS = $clog2(DEPTH + 1)
) (
   input  logic                   clock,
   input  occ_pkg::mem_we_type    we,
   input  logic [SLOT_BITS-1:0]   waddr,
   input  logic [ID_BITS-1:0]     wr_id,
   input  logic                   wr_kind,
   input  logic [63:0]            wr_lat,
   input  logic [63:0]            wr_lon,
   input  logic [LINK_BITS-1:0]   wr_link,
   input  logic [SLOT_BITS-1:0]   raddr,
   output logic [ID_BITS-1:0]     rd_id,
   output logic                   rd_kind,
   output logic [63:0]            rd_lat,
   output logic [63:0]            rd_lon,
   output logic [LINK_BITS-1:0]   rd_link
);
   import occ_pkg::*;

   logic [ID_BITS-1:0]   id_mem   [DEPTH];
   logic                 kind_mem [DEPTH];
   logic [63:0]          lat_mem  [DEPTH];
   logic [63:0]          lon_mem  [DEPTH];
   logic [LINK_BITS-1:0] link_mem [DEPTH];

   logic [ID_BITS-1:0]   rd_id_ff;
   logic                 rd_kind_ff;
   logic [63:0]          rd_lat_ff;
   logic [63:0]          rd_lon_ff;
   logic [LINK_BITS-1:0] rd_link_ff;

   always_ff @(posedge clock) begin
      if (we.data_we) begin
         id_mem[waddr]   <= wr_id;
         kind_mem[waddr] <= wr_kind;
         lat_mem[waddr]  <= wr_lat;
         lon_mem[waddr]  <= wr_lon;
      end
      if (we.link_we) begin
         link_mem[waddr] <= wr_link;
      end
      rd_id_ff   <= id_mem[raddr];
      rd_kind_ff <= kind_mem[raddr];
      rd_lat_ff  <= lat_mem[raddr];
      rd_lon_ff  <= lon_mem[raddr];
      rd_link_ff <= link_mem[raddr];
   end

   assign rd_id   = rd_id_ff;
   assign rd_kind = rd_kind_ff;
   assign rd_lat  = rd_lat_ff;
   assign rd_lon  = rd_lon_ff;
   assign rd_link = rd_link_ff;

endmodule

### rtl/occ_seq.sv
// Sequencer of the command queue: free-slot scan, list walks, id compare.
// Drives occ_entry_mem; uses occ_pkg and assert_macros.svh.
`include "assert_macros.svh"
module occ_seq #(
   parameter int unsigned DEPTH     = 16,
   parameter int unsigned ID_BITS   = 32,
   localparam int unsigned SLOT_BITS = $clog2(DEPTH),
   localparam int unsigned LINK_BITS = $clog2(DEPTH + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  occ_pkg::cmd_req_type   req,
   output logic                   res_valid,
   input  logic                   res_ready,
   output occ_pkg::cmd_rsp_type   res,
   output occ_pkg::mem_we_type    mem_we,
   output logic [SLOT_BITS-1:0]   mem_waddr,
   output logic [ID_BITS-1:0]     wr_id,
   output logic                   wr_kind,
   output logic [63:0]            wr_lat,
   output logic [63:0]            wr_lon,
   output logic [LINK_BITS-1:0]   wr_link,
   output logic [SLOT_BITS-1:0]   mem_raddr,
   input  logic [ID_BITS-1:0]     rd_id,
   input  logic                   rd_kind,
   input  logic [63:0]            rd_lat,
   input  logic [63:0]            rd_lon,
   input  logic [LINK_BITS-1:0]   rd_link
);
   import occ_pkg::*;

   localparam logic [LINK_BITS-1:0] NIL      = LINK_BITS'(DEPTH);
   localparam logic [SLOT_BITS-1:0] LAST_SLOT = SLOT_BITS'(DEPTH - 1);

   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_SCAN      = 4'd1;
   localparam logic [3:0] S_INS_PLACE = 4'd2;
   localparam logic [3:0] S_INS_WALK  = 4'd3;
   localparam logic [3:0] S_INS_LINK  = 4'd4;
   localparam logic [3:0] S_POP_OLD   = 4'd5;
   localparam logic [3:0] S_POP_NEW   = 4'd6;
   localparam logic [3:0] S_DEL_CUR   = 4'd7;
   localparam logic [3:0] S_DEL_NEXT  = 4'd8;
   localparam logic [3:0] S_DONE      = 4'd9;

   logic [3:0]           state_ff,  state_in;
   logic [DEPTH-1:0]     used_ff,   used_in;
   logic [LINK_BITS-1:0] head_ff,   head_in;
   logic [ID_BITS-1:0]   fresh_ff,  fresh_in;
   logic [ID_BITS-1:0]   last_ff,   last_in;
   cmd_req_type          cmd_ff,    cmd_in;
   logic [LINK_BITS-1:0] addr_ff,   addr_in;
   logic [LINK_BITS-1:0] cur_ff,    cur_in;
   logic [SLOT_BITS-1:0] slot_ff,   slot_in;
   logic [SLOT_BITS-1:0] scan_ff,   scan_in;
   cmd_rsp_type          res_ff,    res_in;

   logic [LINK_BITS-1:0] rd_next;
   logic [ID_BITS-1:0]   ref_cmp;

   logic                 head_live;
   logic                 head_marked;
   logic                 idle_empty;
   logic                 no_used;
   logic                 full_done;
   logic                 all_used;
   logic                 flush_take;
   logic                 flush_clean;

   // read data always belongs to the entry at addr_ff
   assign rd_next   = (rd_link < NIL) ? rd_link : NIL;
   assign ref_cmp   = ID_BITS'(cmd_ff.ref_id);
   assign mem_raddr = addr_in[SLOT_BITS-1:0];
   assign wr_id     = fresh_ff;
   assign wr_kind   = cmd_ff.command_kind;
   assign wr_lat    = cmd_ff.latitude_in;
   assign wr_lon    = cmd_ff.longitude_in;

   assign req_ready = (state_ff == S_IDLE);
   assign res_valid = (state_ff == S_DONE);
   assign res       = res_ff;

   always_comb begin
      state_in  = state_ff;
      used_in   = used_ff;
      head_in   = head_ff;
      fresh_in  = fresh_ff;
      last_in   = last_ff;
      cmd_in    = cmd_ff;
      addr_in   = addr_ff;
      cur_in    = cur_ff;
      slot_in   = slot_ff;
      scan_in   = scan_ff;
      res_in    = res_ff;
      mem_we    = '0;
      mem_waddr = slot_ff;
      wr_link   = head_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in = req;
               res_in = '0;
               case (req.operation)
                  OP_INSERT: begin
                     scan_in  = '0;
                     state_in = S_SCAN;
                  end
                  OP_POP: begin
                     if (head_ff == NIL) begin
                        res_in.status = ST_NONE_PENDING;
                        state_in      = S_DONE;
                     end else begin
                        addr_in  = head_ff;
                        state_in = S_POP_OLD;
                     end
                  end
                  OP_DELETE: begin
                     if (head_ff == NIL) begin
                        res_in.status = ST_NOT_FOUND;
                        state_in      = S_DONE;
                     end else begin
                        addr_in  = head_ff;
                        state_in = S_DEL_CUR;
                     end
                  end
                  default: begin
                     used_in       = '0;
                     head_in       = NIL;
                     fresh_in      = ID_BITS'(1);
                     last_in       = '0;
                     res_in.status = ST_FLUSHED;
                     state_in      = S_DONE;
                  end
               endcase
            end
         end

         // lowest free slot, one slot a cycle
         S_SCAN: begin
            if (!used_ff[scan_ff]) begin
               slot_in  = scan_ff;
               state_in = S_INS_PLACE;
            end else if (scan_ff == LAST_SLOT) begin
               res_in.status = ST_FULL;
               state_in      = S_DONE;
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end

         S_INS_PLACE: begin
            mem_we.data_we     = 1'b1;
            used_in[slot_ff]   = 1'b1;
            res_in.assigned_id = 32'(fresh_ff);
            fresh_in           = fresh_ff + 1'b1;
            if (head_ff == NIL || last_ff == ref_cmp) begin
               mem_we.link_we       = 1'b1;
               head_in              = LINK_BITS'(slot_ff);
               res_in.status        = ST_HEAD_INSERT;
               res_in.notify        = 1'b1;
               res_in.destination   = DEST_NAV;
               res_in.message_kind  = MSG_POSITION;
               res_in.latitude_out  = cmd_ff.latitude_in;
               res_in.longitude_out = cmd_ff.longitude_in;
               state_in             = S_DONE;
            end else begin
               addr_in  = head_ff;
               state_in = S_INS_WALK;
            end
         end

         // stop at the tail or at the first id match
         S_INS_WALK: begin
            if (rd_next == NIL || rd_id == ref_cmp) begin
               mem_we.link_we = 1'b1;
               wr_link        = rd_next;
               state_in       = S_INS_LINK;
            end else begin
               addr_in = rd_next;
            end
         end

         S_INS_LINK: begin
            mem_we.link_we = 1'b1;
            mem_waddr      = addr_ff[SLOT_BITS-1:0];
            wr_link        = LINK_BITS'(slot_ff);
            res_in.status  = ST_LATER_INSERT;
            state_in       = S_DONE;
         end

         S_POP_OLD: begin
            last_in                         = rd_id;
            used_in[addr_ff[SLOT_BITS-1:0]] = 1'b0;
            head_in                         = rd_next;
            if (rd_next == NIL) begin
               res_in.status = ST_NONE_PENDING;
               state_in      = S_DONE;
            end else begin
               addr_in  = rd_next;
               state_in = S_POP_NEW;
            end
         end

         S_POP_NEW: begin
            res_in.status = ST_NEXT_PENDING;
            res_in.notify = 1'b1;
            if (rd_kind == MSG_POSITION) begin
               res_in.destination   = DEST_NAV;
               res_in.message_kind  = MSG_POSITION;
               res_in.latitude_out  = rd_lat;
               res_in.longitude_out = rd_lon;
            end else begin
               res_in.destination  = DEST_CAMERA;
               res_in.message_kind = MSG_CAMERA;
            end
            state_in = S_DONE;
         end

         S_DEL_CUR: begin
            if (rd_next == NIL) begin
               res_in.status = ST_NOT_FOUND;
               state_in      = S_DONE;
            end else begin
               cur_in   = addr_ff;
               addr_in  = rd_next;
               state_in = S_DEL_NEXT;
            end
         end

         // rd holds the successor of cur_ff; the head itself is never removed
         S_DEL_NEXT: begin
            if (rd_id == ref_cmp) begin
               mem_we.link_we                  = 1'b1;
               mem_waddr                       = cur_ff[SLOT_BITS-1:0];
               wr_link                         = rd_next;
               used_in[addr_ff[SLOT_BITS-1:0]] = 1'b0;
               res_in.status                   = ST_DELETED;
               if (cur_ff == head_ff) begin
                  res_in.notify        = 1'b1;
                  res_in.destination   = DEST_NAV;
                  res_in.message_kind  = MSG_POSITION;
                  res_in.latitude_out  = rd_lat;
                  res_in.longitude_out = rd_lon;
               end
               state_in = S_DONE;
            end else if (rd_next == NIL) begin
               res_in.status = ST_NOT_FOUND;
               state_in      = S_DONE;
            end else begin
               cur_in  = addr_ff;
               addr_in = rd_next;
            end
         end

         S_DONE: begin
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         used_ff  <= '0;
         head_ff  <= NIL;
         fresh_ff <= ID_BITS'(1);
         last_ff  <= '0;
      end else begin
         state_ff <= state_in;
         used_ff  <= used_in;
         head_ff  <= head_in;
         fresh_ff <= fresh_in;
         last_ff  <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      addr_ff <= addr_in;
      cur_ff  <= cur_in;
      slot_ff <= slot_in;
      scan_ff <= scan_in;
      res_ff  <= res_in;
   end

   assign head_live   = (head_ff != NIL);
   assign head_marked = used_ff[head_ff[SLOT_BITS-1:0]];
   assign idle_empty  = (state_ff == S_IDLE) && (head_ff == NIL);
   assign no_used     = (used_ff == '0);
   assign full_done   = (state_ff == S_DONE) && (res_ff.status == ST_FULL);
   assign all_used    = &used_ff;
   assign flush_take  = (state_ff == S_IDLE) && req_valid && (req.operation == OP_FLUSH);
   assign flush_clean = (used_ff == '0) && (head_ff == NIL) && (fresh_ff == ID_BITS'(1));

   `OCC_ASSERT_IMPLIES(a_head_used, clock, reset, head_live, head_marked, "head slot unused")
   `OCC_ASSERT_IMPLIES(a_idle_empty, clock, reset, idle_empty, no_used, "used slot, empty queue")
   `OCC_ASSERT_IMPLIES(a_full_flag, clock, reset, full_done, all_used, "full with a free slot")
   `OCC_ASSERT_NEXT(a_flush_clears, clock, reset, flush_take, flush_clean, "flush left state")

endmodule
